### rtl/kgnms_pkg.sv
// Package for the keypoint grid suppression block: sizes, codes and beat types.
`default_nettype none

package kgnms_pkg;

    // Blocked map geometry and window limit.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_RADIUS = 7;

    // Address widths of the map: one memory word per pixel row.
    localparam int ROW_AW = $clog2(MAX_HEIGHT);
    localparam int COL_AW = $clog2(MAX_WIDTH);

    // Width of the bound arithmetic; it holds a coordinate plus a margin or
    // a radius and the 10-bit image size registers.
    localparam int DIM_AW = (MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
    localparam int CW     = (DIM_AW + 2 > 11) ? DIM_AW + 2 : 11;

    localparam int CFG_DW = 10;

    // Operation codes of an input beat.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        CFG_NMS_RADIUS    = 2'd0,
        CFG_BORDER_MARGIN = 2'd1,
        CFG_IMAGE_WIDTH   = 2'd2,
        CFG_IMAGE_HEIGHT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       op;
        logic [8:0] point_row;
        logic [8:0] point_col;
    } point_t;

    typedef struct packed {
        logic       kept;
        logic       inside_border;
        logic [8:0] out_row;
        logic [8:0] out_col;
    } result_t;

    typedef struct packed {
        logic                 en;
        logic [ROW_AW-1:0]    addr;
        logic [MAX_WIDTH-1:0] data;
    } map_wr_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] addr;
    } map_rd_t;

endpackage

`default_nettype wire

### rtl/kgnms_map_ram.sv
// Blocked map memory: one pixel row per word, one write and one registered read port.
`default_nettype none

module kgnms_map_ram (
    input  wire logic                            clk,
    input  wire kgnms_pkg::map_wr_t              wr,
    input  wire kgnms_pkg::map_rd_t              rd,
    output logic [kgnms_pkg::MAX_WIDTH-1:0]      rd_data
);

    logic [kgnms_pkg::MAX_WIDTH-1:0] mem [kgnms_pkg::MAX_HEIGHT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

### rtl/keypoint_grid_nms_core.sv
// Top level of the keypoint grid non-maximum suppression block.
//
// Candidate points arrive on the point channel (valid/ready), already sorted
// by descending score. Each beat is either a candidate (row, column) or a
// clear command that empties the blocked map for a new frame. Every input
// beat produces exactly one result beat on the result channel: the kept flag,
// the border flag and the echoed coordinates (all zero for a clear). The
// configuration channel writes the radius, margin and image size; it is always
// ready. The user must write it only while the block is idle; no check is made.
//
// The map lives in a memory with one 512-bit word per pixel row. A kept point
// is handled by a small sequencer that reads one row and writes the previous
// one back with the window mask ORed in, so one row goes by per cycle.
// The result register is loaded from S_EMIT: a point outside the image goes
// there straight away, a blocked point passes through S_TEST first, and a
// kept point goes through S_TEST and then S_FILL for the rows of its window.
// A clear sweeps all MAX_HEIGHT rows, one per cycle, before its result is
// loaded. The block takes one item at a time; point_ready is high only
// between items. After reset the same clearing sweep runs (all MAX_HEIGHT
// rows, no result) before point_ready rises. A result waits in the output
// register while the receiver stalls, and the next item is accepted meanwhile,
// but its result is held back until the register has been emptied.
`default_nettype none

module keypoint_grid_nms_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              point_valid,
    output logic                                   point_ready,
    input  wire kgnms_pkg::point_t                 point_data,

    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output kgnms_pkg::result_t                     result_data,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire kgnms_pkg::cfg_idx_t               cfg_index,
    input  wire logic [kgnms_pkg::CFG_DW-1:0]      cfg_data
);

    localparam int CW     = kgnms_pkg::CW;
    localparam int ROW_AW = kgnms_pkg::ROW_AW;
    localparam int COL_AW = kgnms_pkg::COL_AW;
    localparam int MW     = kgnms_pkg::MAX_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TEST,
        S_FILL,
        S_EMIT
    } state_t;

    // Configuration registers.
    logic [2:0] nms_radius_reg;
    logic [7:0] border_margin_reg;
    logic [9:0] image_width_reg;
    logic [9:0] image_height_reg;

    // Sequencer registers.
    state_t              state_reg, state_next;
    logic [ROW_AW-1:0]   clr_ptr_reg, clr_ptr_next;
    logic                clr_emit_reg, clr_emit_next;
    logic [ROW_AW-1:0]   r0_reg, r0_next;
    logic [ROW_AW-1:0]   r1_reg, r1_next;
    logic [COL_AW-1:0]   c0_reg, c0_next;
    logic [COL_AW-1:0]   c1_reg, c1_next;
    logic [COL_AW-1:0]   col_idx_reg, col_idx_next;
    logic                inb_reg, inb_next;
    logic [ROW_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ROW_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic                more_reg, more_next;
    logic [MW-1:0]       mask_reg, mask_next;
    kgnms_pkg::result_t  res_reg, res_next;
    logic                result_valid_reg, result_valid_next;
    kgnms_pkg::result_t  result_data_reg, result_data_next;

    kgnms_pkg::map_wr_t  map_wr;
    kgnms_pkg::map_rd_t  map_rd;
    logic [MW-1:0]       map_rd_data;

    kgnms_map_ram u_map (
        .clk     (clk),
        .wr      (map_wr),
        .rd      (map_rd),
        .rd_data (map_rd_data)
    );

    assign point_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;
    assign cfg_ready    = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nms_radius_reg    <= 3'd4;
            border_margin_reg <= 8'd4;
            image_width_reg   <= 10'd512;
            image_height_reg  <= 10'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kgnms_pkg::CFG_NMS_RADIUS:    nms_radius_reg    <= cfg_data[2:0];
                kgnms_pkg::CFG_BORDER_MARGIN: border_margin_reg <= cfg_data[7:0];
                kgnms_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[9:0];
                kgnms_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [CW-1:0] w, h, prow, pcol, rad, mg;
        logic [CW-1:0] r0_c, r1_c, c0_c, c1_c;
        logic          in_image;
        logic          out_free;

        state_next        = state_reg;
        clr_ptr_next      = clr_ptr_reg;
        clr_emit_next     = clr_emit_reg;
        r0_next           = r0_reg;
        r1_next           = r1_reg;
        c0_next           = c0_reg;
        c1_next           = c1_reg;
        col_idx_next      = col_idx_reg;
        inb_next          = inb_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        more_next         = more_reg;
        mask_next         = mask_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg;
        result_data_next  = result_data_reg;
        map_wr            = '0;
        map_rd            = '0;

        // Image size clipped to the map; radius saturated to the window limit.
        w = (CW'(image_width_reg) > CW'(kgnms_pkg::MAX_WIDTH))
            ? CW'(kgnms_pkg::MAX_WIDTH) : CW'(image_width_reg);
        h = (CW'(image_height_reg) > CW'(kgnms_pkg::MAX_HEIGHT))
            ? CW'(kgnms_pkg::MAX_HEIGHT) : CW'(image_height_reg);
        rad = (CW'(nms_radius_reg) > CW'(kgnms_pkg::MAX_RADIUS))
            ? CW'(kgnms_pkg::MAX_RADIUS) : CW'(nms_radius_reg);
        mg   = CW'(border_margin_reg);
        prow = CW'(point_data.point_row);
        pcol = CW'(point_data.point_col);

        in_image = (prow < h) && (pcol < w);
        r0_c     = (prow >= rad) ? prow - rad : '0;
        r1_c     = (prow + rad > h - CW'(1)) ? h - CW'(1) : prow + rad;
        c0_c     = (pcol >= rad) ? pcol - rad : '0;
        c1_c     = (pcol + rad > w - CW'(1)) ? w - CW'(1) : pcol + rad;

        out_free = !result_valid_reg || result_ready;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                map_wr.en    = 1'b1;
                map_wr.addr  = clr_ptr_reg;
                map_wr.data  = '0;
                clr_ptr_next = clr_ptr_reg + ROW_AW'(1);
                if (clr_ptr_reg == ROW_AW'(kgnms_pkg::MAX_HEIGHT - 1))
                begin
                    clr_ptr_next = '0;
                    res_next     = '0;
                    state_next   = clr_emit_reg ? S_EMIT : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (point_valid)
                begin
                    res_next.kept          = 1'b0;
                    res_next.inside_border = 1'b0;
                    res_next.out_row       = point_data.point_row;
                    res_next.out_col       = point_data.point_col;
                    r0_next      = ROW_AW'(r0_c);
                    r1_next      = ROW_AW'(r1_c);
                    c0_next      = COL_AW'(c0_c);
                    c1_next      = COL_AW'(c1_c);
                    col_idx_next = COL_AW'(pcol);
                    inb_next     = (prow >= mg) && (prow + mg < h)
                                && (pcol >= mg) && (pcol + mg < w);
                    if (point_data.op == kgnms_pkg::OP_CLEAR)
                    begin
                        clr_ptr_next  = '0;
                        clr_emit_next = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    else if (!in_image)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // Fetch the candidate's own row to test its pixel.
                        map_rd.en   = 1'b1;
                        map_rd.addr = ROW_AW'(prow);
                        state_next  = S_TEST;
                    end
                end
            end

            S_TEST:
            begin
                if (map_rd_data[col_idx_reg])
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    for (int i = 0; i < MW; i++)
                    begin
                        mask_next[i] = (COL_AW'(i) >= c0_reg) && (COL_AW'(i) <= c1_reg);
                    end
                    res_next.kept          = 1'b1;
                    res_next.inside_border = inb_reg;
                    map_rd.en   = 1'b1;
                    map_rd.addr = r0_reg;
                    wr_ptr_next = r0_reg;
                    rd_ptr_next = r0_reg + ROW_AW'(1);
                    more_next   = (r0_reg != r1_reg);
                    state_next  = S_FILL;
                end
            end

            S_FILL:
            begin
                // Write back the row read last cycle while fetching the next.
                map_wr.en   = 1'b1;
                map_wr.addr = wr_ptr_reg;
                map_wr.data = map_rd_data | mask_reg;
                if (more_reg)
                begin
                    map_rd.en   = 1'b1;
                    map_rd.addr = rd_ptr_reg;
                    wr_ptr_next = rd_ptr_reg;
                    rd_ptr_next = rd_ptr_reg + ROW_AW'(1);
                    more_next   = (rd_ptr_reg != r1_reg);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_data_next  = res_reg;
                    clr_emit_next     = 1'b0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_ptr_reg      <= '0;
            clr_emit_reg     <= 1'b0;
            more_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_ptr_reg      <= clr_ptr_next;
            clr_emit_reg     <= clr_emit_next;
            more_reg         <= more_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg          <= r0_next;
        r1_reg          <= r1_next;
        c0_reg          <= c0_next;
        c1_reg          <= c1_next;
        col_idx_reg     <= col_idx_next;
        inb_reg         <= inb_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        mask_reg        <= mask_next;
        res_reg         <= res_next;
        result_data_reg <= result_data_next;
    end

    // An accepted item always closes the input in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_ready) |=> !point_ready)
        else $error("point_ready stayed high after an accepted beat");

    // Window write-back stays within the clipped rows of the window.
    a_fill_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (map_wr.en && map_wr.addr >= r0_reg
                                   && map_wr.addr <= r1_reg))
        else $error("window write outside the suppression rows");

    // The clearing sweep writes every cycle and never lets an item in.
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (map_wr.en && !point_ready && !map_rd.en))
        else $error("clearing sweep interrupted");

    // The border flag is only ever raised for a kept point.
    a_border_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result_data.inside_border || result_data.kept))
        else $error("inside_border set on a dropped point");

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for keypoint_grid_nms_core: directed table, framed random traffic.
`timescale 1ns / 100ps

module tb;

    // Run shape. Every beat produces exactly one result beat, so the store of
    // expected results alone tells when the block has gone idle.
    localparam int NUM_SEGMENTS = 9;
    localparam int SEG_ITEMS    = 144;
    // Segment in which the receiver stops for a long stretch, and segment in
    // which the sender waits for every expected result before going on.
    localparam int HOLD_SEG     = 6;
    localparam int PAUSE_SEG    = 1;
    // Long enough that the output register fills and the next point is
    // accepted and finished behind it, so point_ready stays low a while.
    localparam int HOLD_CYCLES  = 400;
    // Slowest correct run: about 1.3k beats, every one a clear, each result
    // stalled by the receiver, plus sender gaps and the sweep after reset,
    // taken several times over.
    localparam int CYCLE_LIMIT  = 4_000_000;

    localparam int MAX_W = kgnms_pkg::MAX_WIDTH;
    localparam int MAX_H = kgnms_pkg::MAX_HEIGHT;
    localparam int MAX_R = kgnms_pkg::MAX_RADIUS;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          point_valid  = 1'b0;
    logic                          point_ready;
    kgnms_pkg::point_t             point_data   = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    kgnms_pkg::result_t            result_data;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    kgnms_pkg::cfg_idx_t           cfg_index    = kgnms_pkg::CFG_NMS_RADIUS;
    logic [kgnms_pkg::CFG_DW-1:0]  cfg_data     = '0;

    keypoint_grid_nms_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point_data   (point_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the blocked map and the registers.
    // ------------------------------------------------------------------
    bit [MAX_W-1:0] blocked_rows [MAX_H];
    int             cur_radius = 4;
    int             cur_margin = 4;
    int             cur_width  = 512;
    int             cur_height = 512;

    kgnms_pkg::result_t pending_results [$];

    // Bookkeeping for the summary and the verdict.
    int fail_count    = 0;
    int beats_sent    = 0;
    int clears_sent   = 0;
    int kept_seen     = 0;
    int border_seen   = 0;
    int results_seen  = 0;
    int settings_used = 1;
    int cycle_count   = 0;

    // Idle rates in percent, and the request for a long receiver hold.
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;

    // Directed rows may carry an expectation typed in by hand; when set, it
    // replaces the predicted result for the beat being offered.
    bit                 pin_active = 1'b0;
    kgnms_pkg::result_t pin_want   = '0;

    // Works out the result of one accepted beat and updates the map. The image
    // size is clipped to the map, and the window is clipped to the image.
    function automatic kgnms_pkg::result_t predict_nms_result(input kgnms_pkg::point_t beat);
        kgnms_pkg::result_t res;
        int                 row, col, w, h, rad, r0, r1, c0, c1;
        res = '0;
        if (beat.op == kgnms_pkg::OP_CLEAR)
        begin
            for (int r = 0; r < MAX_H; r++)
                blocked_rows[r] = '0;
            return res;
        end
        row = int'(beat.point_row);
        col = int'(beat.point_col);
        w   = (cur_width  > MAX_W) ? MAX_W : cur_width;
        h   = (cur_height > MAX_H) ? MAX_H : cur_height;
        rad = (cur_radius > MAX_R) ? MAX_R : cur_radius;
        res.out_row = beat.point_row;
        res.out_col = beat.point_col;
        if (row < h && col < w && !blocked_rows[row][col])
        begin
            r0 = (row - rad < 0) ? 0 : row - rad;
            r1 = (row + rad > h - 1) ? h - 1 : row + rad;
            c0 = (col - rad < 0) ? 0 : col - rad;
            c1 = (col + rad > w - 1) ? w - 1 : col + rad;
            for (int r = r0; r <= r1; r++)
                for (int c = c0; c <= c1; c++)
                    blocked_rows[r][c] = 1'b1;
            res.kept = 1'b1;
            res.inside_border = (row >= cur_margin && row < h - cur_margin &&
                                 col >= cur_margin && col < w - cur_margin);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything here samples at the rising edge, so it sees the
    // same pre-edge values the block's flops see.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        kgnms_pkg::result_t want;
        kgnms_pkg::result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    kgnms_pkg::CFG_NMS_RADIUS:    cur_radius = int'(cfg_data[2:0]);
                    kgnms_pkg::CFG_BORDER_MARGIN: cur_margin = int'(cfg_data[7:0]);
                    kgnms_pkg::CFG_IMAGE_WIDTH:   cur_width  = int'(cfg_data);
                    kgnms_pkg::CFG_IMAGE_HEIGHT:  cur_height = int'(cfg_data);
                    default: ;
                endcase
            end
            if (point_valid && point_ready)
            begin
                want = predict_nms_result(point_data);
                if (pin_active)
                    want = pin_want;
                pending_results.push_back(want);
                beats_sent++;
                if (point_data.op == kgnms_pkg::OP_CLEAR)
                    clears_sent++;
            end
            if (result_valid && result_ready)
            begin
                got = result_data;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", got);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.kept !== want.kept)
                    begin
                        $error("kept: expected %0d, got %0d", want.kept, got.kept);
                        fail_count++;
                    end
                    if (got.inside_border !== want.inside_border)
                    begin
                        $error("inside_border: expected %0d, got %0d",
                               want.inside_border, got.inside_border);
                        fail_count++;
                    end
                    if (got.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                        fail_count++;
                    end
                    if (got.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                        fail_count++;
                    end
                    if (want.kept)
                        kept_seen++;
                    if (want.inside_border)
                        border_seen++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keypoint_grid_nms_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls at the current rate, plus one long hold that
    // this process counts down on its own while the sender keeps offering.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int hold_seen = 0;

    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks. They are entered and left at a falling edge. After an
    // accepted beat, point_valid is left high so that a back-to-back beat
    // never sees valid dropped and raised in the same step.
    // ------------------------------------------------------------------
    task automatic push_beat(input kgnms_pkg::point_t beat);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            point_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        point_valid <= 1'b1;
        point_data  <= beat;
        do @(posedge clk); while (!point_ready);
        @(negedge clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    // At least one falling edge passes, so a following beat raises valid in
    // a later step than the one that lowered it.
    task automatic drain_results();
        point_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input kgnms_pkg::cfg_idx_t idx, input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[kgnms_pkg::CFG_DW-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input int rad, input int mg, input int w, input int h);
        write_reg(kgnms_pkg::CFG_NMS_RADIUS, rad);
        write_reg(kgnms_pkg::CFG_BORDER_MARGIN, mg);
        write_reg(kgnms_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(kgnms_pkg::CFG_IMAGE_HEIGHT, h);
        settings_used++;
    endtask

    // Random traffic shaped as frames: a clear, then a run of candidates
    // mostly inside the image, with duplicates and near neighbors so that
    // suppression actually fires. Stray clears and points anywhere in the
    // 9-bit range (often outside a small image) make up the noise.
    task automatic run_segment(input int seg, input int n_items);
        kgnms_pkg::point_t beat;
        kgnms_pkg::point_t prev;
        int                frame_left, roll, w, h, r, c;
        prev       = '0;
        frame_left = 0;
        w = (cur_width  > MAX_W) ? MAX_W : cur_width;
        h = (cur_height > MAX_H) ? MAX_H : cur_height;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
            begin
                if (seg == HOLD_SEG)
                    hold_requests++;
                if (seg == PAUSE_SEG)
                    drain_results();
            end
            roll = $urandom_range(99);
            if (frame_left == 0)
            begin
                beat       = {kgnms_pkg::OP_CLEAR, 9'($urandom), 9'($urandom)};
                frame_left = $urandom_range(40, 4);
            end
            else
            begin
                frame_left--;
                if (roll < 3)
                begin
                    beat = {kgnms_pkg::OP_CLEAR, 9'($urandom), 9'($urandom)};
                end
                else if (roll < 10)
                begin
                    beat = prev;
                end
                else if (roll < 30)
                begin
                    r    = int'(prev.point_row) + int'($urandom_range(16)) - 8;
                    c    = int'(prev.point_col) + int'($urandom_range(16)) - 8;
                    beat = {kgnms_pkg::OP_POINT, 9'(r), 9'(c)};
                end
                else if (roll < 42 || w == 0 || h == 0)
                begin
                    beat = {kgnms_pkg::OP_POINT, 9'($urandom), 9'($urandom)};
                end
                else
                begin
                    r    = $urandom_range(h - 1, 0);
                    c    = $urandom_range(w - 1, 0);
                    beat = {kgnms_pkg::OP_POINT, 9'(r), 9'(c)};
                end
            end
            if (beat.op == kgnms_pkg::OP_POINT)
                prev = beat;
            push_beat(beat);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Register rows are written with the block idle. Beat
    // rows with pinned set carry a hand-typed result; the rest go through
    // the predictor. Comments give the register state in force.
    // ------------------------------------------------------------------
    typedef enum logic {PLAN_REG, PLAN_BEAT} plan_kind_t;

    typedef struct {
        plan_kind_t          kind;
        kgnms_pkg::cfg_idx_t reg_idx;
        int                  reg_val;
        kgnms_pkg::point_t   beat;
        bit                  pinned;
        kgnms_pkg::result_t  want;
    } plan_row_t;

    localparam kgnms_pkg::cfg_idx_t R_RAD = kgnms_pkg::CFG_NMS_RADIUS;
    localparam kgnms_pkg::cfg_idx_t R_MG  = kgnms_pkg::CFG_BORDER_MARGIN;
    localparam kgnms_pkg::cfg_idx_t R_W   = kgnms_pkg::CFG_IMAGE_WIDTH;
    localparam kgnms_pkg::cfg_idx_t R_H   = kgnms_pkg::CFG_IMAGE_HEIGHT;
    localparam logic                P_PT  = kgnms_pkg::OP_POINT;
    localparam logic                P_CLR = kgnms_pkg::OP_CLEAR;

    plan_row_t plan_rows [34] = '{
        // Reset values: radius 4, margin 4, 512 x 512.
        // Corner point is kept but lies in the margin; its copy finds its own
        // pixel blocked; (4,4) sits on the edge of the first window.
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd0}, 1'b1,
          {1'b1, 1'b0, 9'd0, 9'd0}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd0}, 1'b1,
          {1'b0, 1'b0, 9'd0, 9'd0}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd4, 9'd4}, 1'b1,
          {1'b0, 1'b0, 9'd4, 9'd4}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd5, 9'd5}, 1'b1,
          {1'b1, 1'b1, 9'd5, 9'd5}},
        // Far corner, then a point inside its clipped window.
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd511, 9'd511}, 1'b1,
          {1'b1, 1'b0, 9'd511, 9'd511}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd507, 9'd507}, 1'b1,
          {1'b0, 1'b0, 9'd507, 9'd507}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd506, 9'd100}, 1'b1,
          {1'b1, 1'b1, 9'd506, 9'd100}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd507, 9'd100}, 1'b0, '0},
        // Clear with every coordinate bit set: the result is all zero, and the
        // corner is free again afterwards.
        '{PLAN_BEAT, R_RAD, 0, {P_CLR, 9'd511, 9'd511}, 1'b1, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd0}, 1'b1,
          {1'b1, 1'b0, 9'd0, 9'd0}},
        // Width above the map, zero height: nothing is inside.
        '{PLAN_REG, R_W, 1023, '0, 1'b0, '0},
        '{PLAN_REG, R_H, 0, '0, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd5}, 1'b1,
          {1'b0, 1'b0, 9'd0, 9'd5}},
        // One-pixel image.
        '{PLAN_REG, R_W, 1, '0, 1'b0, '0},
        '{PLAN_REG, R_H, 1, '0, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_CLR, 9'd0, 9'd0}, 1'b1, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd0}, 1'b1,
          {1'b1, 1'b0, 9'd0, 9'd0}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd0, 9'd1}, 1'b1,
          {1'b0, 1'b0, 9'd0, 9'd1}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd1, 9'd0}, 1'b1,
          {1'b0, 1'b0, 9'd1, 9'd0}},
        // Radius 0 blocks only the point's own pixel; margin 0 puts the
        // whole image inside the border.
        '{PLAN_REG, R_RAD, 0, '0, 1'b0, '0},
        '{PLAN_REG, R_MG, 0, '0, 1'b0, '0},
        '{PLAN_REG, R_W, 512, '0, 1'b0, '0},
        '{PLAN_REG, R_H, 512, '0, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_CLR, 9'h155, 9'h0AA}, 1'b1, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd100, 9'd100}, 1'b1,
          {1'b1, 1'b1, 9'd100, 9'd100}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd100, 9'd101}, 1'b1,
          {1'b1, 1'b1, 9'd100, 9'd101}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd100, 9'd100}, 1'b1,
          {1'b0, 1'b0, 9'd100, 9'd100}},
        // Largest radius and margin: the border band shrinks to two rows and
        // two columns in the middle.
        '{PLAN_REG, R_RAD, 7, '0, 1'b0, '0},
        '{PLAN_REG, R_MG, 255, '0, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd255, 9'd255}, 1'b1,
          {1'b1, 1'b1, 9'd255, 9'd255}},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd262, 9'd262}, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd263, 9'd263}, 1'b1,
          {1'b1, 1'b0, 9'd263, 9'd263}},
        '{PLAN_REG, R_MG, 0, '0, 1'b0, '0},
        '{PLAN_BEAT, R_RAD, 0, {P_PT, 9'd511, 9'd0}, 1'b1,
          {1'b1, 1'b1, 9'd511, 9'd0}}
    };

    // Register settings of the random segments: radius, margin, width,
    // height. They cover the extremes, images above the map size and
    // one-pixel-wide or one-pixel-tall images.
    int seg_setting [NUM_SEGMENTS][4] = '{
        '{4,   4,  512, 512},
        '{7,   0,  512, 512},
        '{0, 255,  512, 512},
        '{2,   8,   64,  48},
        '{7, 255,   20,  20},
        '{1,   3, 1023, 600},
        '{3,  10,    1, 512},
        '{5,   1,  300,   1},
        '{6,  16,  200, 512}
    };

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        for (int r = 0; r < MAX_H; r++)
            blocked_rows[r] = '0;

        tx_idle_pct = 26;
        rx_idle_pct = 67;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The block sweeps its map after reset; the first beat simply waits
        // for point_ready.
        foreach (plan_rows[i])
        begin
            if (plan_rows[i].kind == PLAN_REG)
            begin
                write_reg(plan_rows[i].reg_idx, plan_rows[i].reg_val);
            end
            else
            begin
                pin_active = plan_rows[i].pinned;
                pin_want   = plan_rows[i].want;
                push_beat(plan_rows[i].beat);
            end
        end
        pin_active = 1'b0;

        // Three idling phases of three settings each: sender gaps with a
        // slow receiver, then the reverse, then full rate.
        for (int s = 0; s < NUM_SEGMENTS; s++)
        begin
            apply_setting(seg_setting[s][0], seg_setting[s][1],
                          seg_setting[s][2], seg_setting[s][3]);
            case (s / 3)
                0:
                begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 67;
                end
                1:
                begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 26;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            run_segment(s, SEG_ITEMS);
        end

        drain_results();
        // A clear is the longest operation; give any stray result time to
        // show up before the verdict.
        repeat (MAX_H + 16) @(negedge clk);

        $display("Summary: %0d beats (%0d clears), %0d results, %0d kept, %0d in border,",
                 beats_sent, clears_sent, results_seen, kept_seen, border_seen);
        $display("  over %0d register settings with sender/receiver stalls and a long hold.",
                 settings_used);
        if (fail_count == 0)
            $display("keypoint_grid_nms_core verification clean");
        else
            $display("keypoint_grid_nms_core verification failed");
        $finish;
    end

endmodule
